/* src/mm_pkg.sv */
`default_nettype none

package mm_pkg;

   // Widths of the fields that do not follow a parameter.
   localparam int INDEX_WIDTH   = 3;
   localparam int KIND_WIDTH    = 2;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int DIM_REG_WIDTH = 4;
   localparam int PRODUCT_WIDTH = 35;

   // Input word kinds.
   typedef logic [KIND_WIDTH-1:0] kind_type;
   localparam kind_type KIND_LOAD_A = 2'd0;
   localparam kind_type KIND_LOAD_B = 2'd1;
   localparam kind_type KIND_START  = 2'd2;

   // Configuration register indexes.
   typedef logic [CSR_IDX_WIDTH-1:0] csr_idx_type;
   localparam csr_idx_type CSR_A_ROWS    = 2'd0;
   localparam csr_idx_type CSR_INNER_LEN = 2'd1;
   localparam csr_idx_type CSR_B_COLS    = 2'd2;

   // Reset value of every dimension register.
   localparam logic [DIM_REG_WIDTH-1:0] DIM_RESET = 4'd8;

endpackage

`default_nettype wire

/* src/matrix_multiply_top.sv */
`default_nettype none

// Matrix multiplier over signed fixed-point elements. Load words (kind load A
// or load B) write one element of A or B into its store; they are accepted
// even while a result word waits on the rsp side. A start word emits every
// element of A*B in row-major order, each the exact dot product over inner_len,
// and marks the final word with rsp_last. One shared multiply-accumulate unit
// does the work: each term of a dot product goes through store read, multiply
// and add, and each product element is then handed to the output register. A
// run keeps req_ready low until its final word is handed over; a result word
// held by rsp_ready stalls the sequencer until the output register frees up.
// Dimension registers above MAX_DIM act as MAX_DIM; a_rows or b_cols of zero
// makes a start emit nothing. Store entries must be written before a run reads
// them. The stores need no clearing after reset.
module matrix_multiply_top #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  wire                                     clock,
   input  wire                                     reset,
   // Input channel.
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire  [mm_pkg::KIND_WIDTH-1:0]           req_kind,
   input  wire  [mm_pkg::INDEX_WIDTH-1:0]          req_row_index,
   input  wire  [mm_pkg::INDEX_WIDTH-1:0]          req_col_index,
   input  wire  signed [ELEM_WIDTH-1:0]            req_elem_value,
   // Result channel.
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic [mm_pkg::INDEX_WIDTH-1:0]          rsp_result_row,
   output logic [mm_pkg::INDEX_WIDTH-1:0]          rsp_result_col,
   output logic signed [mm_pkg::PRODUCT_WIDTH-1:0] rsp_product_value,
   output logic                                    rsp_last,
   // Configuration channel.
   input  wire                                     csr_valid,
   output logic                                    csr_ready,
   input  wire  [mm_pkg::CSR_IDX_WIDTH-1:0]        csr_index,
   input  wire  [mm_pkg::DIM_REG_WIDTH-1:0]        csr_data
);

   localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CNT_W   = $clog2(MAX_DIM + 1);
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int DEPTH   = 1 << ADDR_W;
   localparam int MUL_W   = 2 * ELEM_WIDTH;
   localparam int ACC_W   = (MUL_W + 3 > mm_pkg::PRODUCT_WIDTH) ? MUL_W + 3
                                                                : mm_pkg::PRODUCT_WIDTH;
   localparam int DREG_W  = mm_pkg::DIM_REG_WIDTH;

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_ACC  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [DREG_W-1:0]       a_rows_ff, inner_len_ff, b_cols_ff;
   logic [CNT_W-1:0]        rows_ff, rows_in;
   logic [CNT_W-1:0]        inner_ff, inner_in;
   logic [CNT_W-1:0]        cols_ff, cols_in;
   logic [IDX_W-1:0]        y_ff, y_in;
   logic [IDX_W-1:0]        x_ff, x_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [MUL_W-1:0] product_ff;
   logic signed [ELEM_WIDTH-1:0] a_rd_ff, b_rd_ff;
   logic [ELEM_WIDTH-1:0]   a_mem [DEPTH];
   logic [ELEM_WIDTH-1:0]   b_mem [DEPTH];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [mm_pkg::INDEX_WIDTH-1:0]          rsp_row_ff, rsp_col_ff;
   logic signed [mm_pkg::PRODUCT_WIDTH-1:0] rsp_value_ff;
   logic                    rsp_last_ff;
   logic                    emit_load;

   logic                    req_accept;
   logic                    load_ok;
   logic [ADDR_W-1:0]       wr_addr;
   logic [CNT_W-1:0]        k_next, x_next, y_next;
   logic                    k_done, x_done, y_done;

   // Clamp a dimension register to MAX_DIM.
   function automatic logic [CNT_W-1:0] dim_of(input logic [DREG_W-1:0] r);
      logic [CNT_W-1:0] d;
      if (r > DREG_W'(MAX_DIM)) begin
         d = CNT_W'(MAX_DIM);
      end else begin
         d = CNT_W'(r);
      end
      return d;
   endfunction

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // A load lands only when both indexes fall inside the store.
   assign load_ok = ({1'b0, req_row_index} < DREG_W'(MAX_DIM)) &&
                    ({1'b0, req_col_index} < DREG_W'(MAX_DIM));
   assign wr_addr = {req_row_index[IDX_W-1:0], req_col_index[IDX_W-1:0]};

   // Loop counter end tests.
   assign k_next = CNT_W'(k_ff) + CNT_W'(1);
   assign x_next = CNT_W'(x_ff) + CNT_W'(1);
   assign y_next = CNT_W'(y_ff) + CNT_W'(1);
   assign k_done = (k_next == inner_ff);
   assign x_done = (x_next == cols_ff);
   assign y_done = (y_next == rows_ff);

   // The output register takes a new word when it is empty or being drained.
   assign emit_load = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff    <= mm_pkg::DIM_RESET;
         inner_len_ff <= mm_pkg::DIM_RESET;
         b_cols_ff    <= mm_pkg::DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mm_pkg::CSR_A_ROWS:    a_rows_ff    <= csr_data;
            mm_pkg::CSR_INNER_LEN: inner_len_ff <= csr_data;
            mm_pkg::CSR_B_COLS:    b_cols_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Element stores, written by load words and read one term at a time.
   always_ff @(posedge clock) begin
      if (req_accept && load_ok && (req_kind == mm_pkg::KIND_LOAD_A)) begin
         a_mem[wr_addr] <= req_elem_value;
      end
      if (req_accept && load_ok && (req_kind == mm_pkg::KIND_LOAD_B)) begin
         b_mem[wr_addr] <= req_elem_value;
      end
      if (state_ff == S_READ) begin
         a_rd_ff <= a_mem[{y_ff, k_ff}];
         b_rd_ff <= b_mem[{k_ff, x_ff}];
      end
   end

   // Shared multiplier, registered ahead of the accumulator.
   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         product_ff <= a_rd_ff * b_rd_ff;
      end
   end

   // Sequencer over rows, columns and inner terms.
   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      inner_in     = inner_ff;
      cols_in      = cols_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_kind == mm_pkg::KIND_START)) begin
               rows_in  = dim_of(a_rows_ff);
               inner_in = dim_of(inner_len_ff);
               cols_in  = dim_of(b_cols_ff);
               y_in     = '0;
               x_in     = '0;
               k_in     = '0;
               acc_in   = '0;
               if ((dim_of(a_rows_ff) == '0) || (dim_of(b_cols_ff) == '0)) begin
                  state_in = S_IDLE;
               end else if (dim_of(inner_len_ff) == '0) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_ff + ACC_W'(product_ff);
            if (k_done) begin
               state_in = S_EMIT;
            end else begin
               k_in     = k_ff + IDX_W'(1);
               state_in = S_READ;
            end
         end
         S_EMIT: begin
            if (emit_load) begin
               acc_in = '0;
               k_in   = '0;
               if (x_done && y_done) begin
                  state_in = S_IDLE;
               end else begin
                  if (x_done) begin
                     x_in = '0;
                     y_in = y_ff + IDX_W'(1);
                  end else begin
                     x_in = x_ff + IDX_W'(1);
                  end
                  state_in = (inner_ff == '0) ? S_EMIT : S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rows_ff  <= rows_in;
      inner_ff <= inner_in;
      cols_ff  <= cols_in;
      y_ff     <= y_in;
      x_ff     <= x_in;
      k_ff     <= k_in;
      acc_ff   <= acc_in;
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit_load) begin
         rsp_row_ff   <= mm_pkg::INDEX_WIDTH'(y_ff);
         rsp_col_ff   <= mm_pkg::INDEX_WIDTH'(x_ff);
         rsp_value_ff <= acc_ff[mm_pkg::PRODUCT_WIDTH-1:0];
         rsp_last_ff  <= x_done && y_done;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_row    = rsp_row_ff;
   assign rsp_result_col    = rsp_col_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

/* src/mm_checker.sv */
`default_nettype none

// Port-level checks on the matrix multiplier.
module mm_checker (
   input wire                                     clock,
   input wire                                     reset,
   input wire                                     req_ready,
   input wire                                     rsp_valid,
   input wire                                     rsp_ready,
   input wire  [mm_pkg::INDEX_WIDTH-1:0]          rsp_result_row,
   input wire  [mm_pkg::INDEX_WIDTH-1:0]          rsp_result_col,
   input wire  signed [mm_pkg::PRODUCT_WIDTH-1:0] rsp_product_value,
   input wire                                     rsp_last
);

   // A stalled result word keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_row) &&
         $stable(rsp_result_col) && $stable(rsp_product_value) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // Reset leaves the block empty and ready for input.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   // A word that is not the final one of a run means the run is still busy.
   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input accepted in the middle of a run");

endmodule

bind matrix_multiply_top mm_checker u_mm_checker (.*);

`default_nettype wire

/* verif/matrix_multiply_checker.sv */
module matrix_multiply_checker #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   input  wire                                     req_ready,
   input  wire  [mm_pkg::KIND_WIDTH-1:0]           req_kind,
   input  wire  [mm_pkg::INDEX_WIDTH-1:0]          req_row_index,
   input  wire  [mm_pkg::INDEX_WIDTH-1:0]          req_col_index,
   input  wire  signed [ELEM_WIDTH-1:0]            req_elem_value,
   input  wire                                     rsp_valid,
   input  wire                                     rsp_ready,
   input  wire  [mm_pkg::INDEX_WIDTH-1:0]          rsp_result_row,
   input  wire  [mm_pkg::INDEX_WIDTH-1:0]          rsp_result_col,
   input  wire  signed [mm_pkg::PRODUCT_WIDTH-1:0] rsp_product_value,
   input  wire                                     rsp_last,
   input  wire                                     csr_valid,
   input  wire                                     csr_ready,
   input  wire  [mm_pkg::CSR_IDX_WIDTH-1:0]        csr_index,
   input  wire  [mm_pkg::DIM_REG_WIDTH-1:0]        csr_data,
   output int                                      fail_count,
   output int                                      pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

   // One element of the product as it should appear on the result channel.
   typedef struct {
      logic [mm_pkg::INDEX_WIDTH-1:0]          row;
      logic [mm_pkg::INDEX_WIDTH-1:0]          col;
      logic signed [mm_pkg::PRODUCT_WIDTH-1:0] value;
      logic                                    last;
   } product_word_type;

   product_word_type                      product_fifo[$];
   logic signed [ELEM_WIDTH-1:0]          a_elems[STORE_DEPTH];
   logic signed [ELEM_WIDTH-1:0]          b_elems[STORE_DEPTH];
   logic [mm_pkg::DIM_REG_WIDTH-1:0]      a_rows_reg;
   logic [mm_pkg::DIM_REG_WIDTH-1:0]      inner_len_reg;
   logic [mm_pkg::DIM_REG_WIDTH-1:0]      b_cols_reg;
   int                                    mismatches = 0;

   // Register values above the store size behave as the store size.
   function automatic int clamp_dim(input logic [mm_pkg::DIM_REG_WIDTH-1:0] raw);
      return (raw > MAX_DIM) ? MAX_DIM : int'(raw);
   endfunction

   // Flags and reports one field that differs from its prediction.
   function automatic int field_differs(input string name,
                                        input logic signed [63:0] want,
                                        input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Queues every element of A*B in row-major order, as an exact sum.
   task automatic queue_products();
      int               rows;
      int               inner;
      int               cols;
      longint           sum;
      product_word_type word;
      rows  = clamp_dim(a_rows_reg);
      inner = clamp_dim(inner_len_reg);
      cols  = clamp_dim(b_cols_reg);
      for (int y = 0; y < rows; y++) begin
         for (int x = 0; x < cols; x++) begin
            sum = 0;
            for (int k = 0; k < inner; k++) begin
               sum += longint'(a_elems[y * MAX_DIM + k]) *
                      longint'(b_elems[k * MAX_DIM + x]);
            end
            word.row   = mm_pkg::INDEX_WIDTH'(y);
            word.col   = mm_pkg::INDEX_WIDTH'(x);
            word.value = mm_pkg::PRODUCT_WIDTH'(sum);
            word.last  = (y == rows - 1) && (x == cols - 1);
            product_fifo.push_back(word);
         end
      end
   endtask

   always @(posedge clock) begin
      product_word_type want;
      if (reset) begin
         product_fifo.delete();
         a_rows_reg    = mm_pkg::DIM_RESET;
         inner_len_reg = mm_pkg::DIM_RESET;
         b_cols_reg    = mm_pkg::DIM_RESET;
      end else begin
         // Compare each accepted result word with the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (product_fifo.size() == 0) begin
               $error("unexpected result word: row %0d col %0d value %0d last %0b",
                      rsp_result_row, rsp_result_col, rsp_product_value, rsp_last);
               mismatches++;
            end else begin
               want = product_fifo.pop_front();
               mismatches += field_differs("result_row", want.row, rsp_result_row);
               mismatches += field_differs("result_col", want.col, rsp_result_col);
               mismatches += field_differs("product_value", want.value, rsp_product_value);
               mismatches += field_differs("last", want.last, rsp_last);
            end
         end

         // Track the element stores and start runs on accepted request words.
         if (req_valid && req_ready) begin
            case (req_kind)
               mm_pkg::KIND_LOAD_A: begin
                  if (req_row_index < MAX_DIM && req_col_index < MAX_DIM) begin
                     a_elems[req_row_index * MAX_DIM + req_col_index] = req_elem_value;
                  end
               end
               mm_pkg::KIND_LOAD_B: begin
                  if (req_row_index < MAX_DIM && req_col_index < MAX_DIM) begin
                     b_elems[req_row_index * MAX_DIM + req_col_index] = req_elem_value;
                  end
               end
               mm_pkg::KIND_START: begin
                  queue_products();
               end
               default: begin
               end
            endcase
         end

         // Follow the dimension registers.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mm_pkg::CSR_A_ROWS:    a_rows_reg = csr_data;
               mm_pkg::CSR_INNER_LEN: inner_len_reg = csr_data;
               mm_pkg::CSR_B_COLS:    b_cols_reg = csr_data;
               default: begin
               end
            endcase
         end
      end
      fail_count    <= mismatches;
      pending_count <= product_fifo.size();
   end

endmodule

/* verif/matrix_multiply_top_tb.sv */
module matrix_multiply_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM        = 8;
   localparam int ELEM_WIDTH     = 16;
   localparam int STORE_DEPTH    = MAX_DIM * MAX_DIM;
   localparam int ITEM_TARGET    = 500;
   localparam int SETTLE_CYCLES  = 64;
   localparam int HOLD_CYCLES    = 2000;
   localparam int WATCHDOG_LIMIT = 20000;

   // The fourth kind code is not used by the block and must be ignored.
   localparam mm_pkg::kind_type KIND_UNUSED = 2'd3;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_valid = 1'b0;
   wire                                     req_ready;
   logic [mm_pkg::KIND_WIDTH-1:0]           req_kind = '0;
   logic [mm_pkg::INDEX_WIDTH-1:0]          req_row_index = '0;
   logic [mm_pkg::INDEX_WIDTH-1:0]          req_col_index = '0;
   logic signed [ELEM_WIDTH-1:0]            req_elem_value = '0;
   wire                                     rsp_valid;
   logic                                    rsp_ready = 1'b0;
   wire  [mm_pkg::INDEX_WIDTH-1:0]          rsp_result_row;
   wire  [mm_pkg::INDEX_WIDTH-1:0]          rsp_result_col;
   wire  signed [mm_pkg::PRODUCT_WIDTH-1:0] rsp_product_value;
   wire                                     rsp_last;
   logic                                    csr_valid = 1'b0;
   logic [mm_pkg::CSR_IDX_WIDTH-1:0]        csr_index = '0;
   logic [mm_pkg::DIM_REG_WIDTH-1:0]        csr_data = '0;
   wire                                     csr_ready;
   int                                      fail_count;
   int                                      pending_count;

   // Stimulus bookkeeping: which store entries hold data, and the dimensions.
   bit                               a_loaded[STORE_DEPTH];
   bit                               b_loaded[STORE_DEPTH];
   logic [mm_pkg::DIM_REG_WIDTH-1:0] a_rows_now = mm_pkg::DIM_RESET;
   logic [mm_pkg::DIM_REG_WIDTH-1:0] inner_now = mm_pkg::DIM_RESET;
   logic [mm_pkg::DIM_REG_WIDTH-1:0] b_cols_now = mm_pkg::DIM_RESET;
   int                               items_sent = 0;
   bit                               tx_idle_on = 1'b1;
   bit                               hold_request = 1'b0;
   int                               quiet_cycles = 0;

   matrix_multiply_top #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_elem_value    (req_elem_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_row    (rsp_result_row),
      .rsp_result_col    (rsp_result_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   matrix_multiply_checker #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) product_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_elem_value    (req_elem_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_row    (rsp_result_row),
      .rsp_result_col    (rsp_result_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Element values lean toward the extremes of the signed range, -1 and zero.
   function automatic logic [ELEM_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return ELEM_WIDTH'($urandom);
      endcase
   endfunction

   // Dimension register values: mostly small, sometimes zero, the maximum or beyond.
   function automatic logic [mm_pkg::DIM_REG_WIDTH-1:0] pick_dim();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) return 4'd0;
      if (roll < 8) return mm_pkg::DIM_REG_WIDTH'($urandom_range(9, 15));
      if (roll < 14) return 4'd8;
      return mm_pkg::DIM_REG_WIDTH'($urandom_range(1, 4));
   endfunction

   function automatic int clamp_dim(input logic [mm_pkg::DIM_REG_WIDTH-1:0] raw);
      return (raw > MAX_DIM) ? MAX_DIM : int'(raw);
   endfunction

   // Offers one request word and returns at the edge that accepts it.
   task automatic send_word(input mm_pkg::kind_type kind,
                            input logic [mm_pkg::INDEX_WIDTH-1:0] row,
                            input logic [mm_pkg::INDEX_WIDTH-1:0] col,
                            input logic [ELEM_WIDTH-1:0] value);
      if (tx_idle_on && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_row_index  <= row;
      req_col_index  <= col;
      req_elem_value <= value;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      if (kind == mm_pkg::KIND_LOAD_A) a_loaded[row * MAX_DIM + col] = 1'b1;
      if (kind == mm_pkg::KIND_LOAD_B) b_loaded[row * MAX_DIM + col] = 1'b1;
      if (kind != KIND_UNUSED) items_sent++;
   endtask

   // Writes one dimension register; the block is idle whenever this is called.
   task automatic write_reg(input mm_pkg::csr_idx_type idx,
                            input logic [mm_pkg::DIM_REG_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         mm_pkg::CSR_A_ROWS:    a_rows_now = data;
         mm_pkg::CSR_INNER_LEN: inner_now = data;
         mm_pkg::CSR_B_COLS:    b_cols_now = data;
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // Loads every operand entry the next run reads that still lacks data, and
   // rewrites a share of the others.
   task automatic load_operands(input int rewrite_pct);
      int rows;
      int inner;
      int cols;
      rows  = clamp_dim(a_rows_now);
      inner = clamp_dim(inner_now);
      cols  = clamp_dim(b_cols_now);
      for (int y = 0; y < rows; y++) begin
         for (int k = 0; k < inner; k++) begin
            if (!a_loaded[y * MAX_DIM + k] || $urandom_range(0, 99) < rewrite_pct) begin
               send_word(mm_pkg::KIND_LOAD_A, mm_pkg::INDEX_WIDTH'(y),
                         mm_pkg::INDEX_WIDTH'(k), pick_value());
            end
         end
      end
      for (int k = 0; k < inner; k++) begin
         for (int x = 0; x < cols; x++) begin
            if (!b_loaded[k * MAX_DIM + x] || $urandom_range(0, 99) < rewrite_pct) begin
               send_word(mm_pkg::KIND_LOAD_B, mm_pkg::INDEX_WIDTH'(k),
                         mm_pkg::INDEX_WIDTH'(x), pick_value());
            end
         end
      end
   endtask

   // A stray word: a load anywhere in the stores, or the unused kind.
   task automatic send_noise();
      mm_pkg::kind_type kind;
      if ($urandom_range(0, 7) == 0) kind = KIND_UNUSED;
      else kind = $urandom_range(0, 1) ? mm_pkg::KIND_LOAD_B : mm_pkg::KIND_LOAD_A;
      send_word(kind, mm_pkg::INDEX_WIDTH'($urandom), mm_pkg::INDEX_WIDTH'($urandom),
                pick_value());
   endtask

   // A start word with random (ignored) row, column and value.
   task automatic send_start();
      send_word(mm_pkg::KIND_START, mm_pkg::INDEX_WIDTH'($urandom),
                mm_pkg::INDEX_WIDTH'($urandom), ELEM_WIDTH'($urandom));
   endtask

   // Waits until every predicted word has come back and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result receiver: random stalls in some stretches, none in others, and one
   // long hold-off on request so that the block backs up into its input.
   initial begin
      int stall_left;
      bit hold_taken;
      bit rx_idle_on;
      stall_left = 0;
      hold_taken = 1'b0;
      rx_idle_on = 1'b1;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 499) == 0) rx_idle_on = !rx_idle_on;
            if (rx_idle_on && $urandom_range(0, 99) < 25) stall_left = pick_gap();
         end
      end
   end

   // Watchdog: ends the run when no word has moved on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[matrix_multiply_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int rounds;
      int phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 2x2x2 product, mostly over the extreme element values; loads outside the
      // current dimensions are still stored, and the unused kind is ignored.
      write_reg(mm_pkg::CSR_A_ROWS, 4'd2);
      write_reg(mm_pkg::CSR_INNER_LEN, 4'd2);
      write_reg(mm_pkg::CSR_B_COLS, 4'd2);
      send_word(mm_pkg::KIND_LOAD_A, 3'd0, 3'd0, 16'h8000);
      send_word(mm_pkg::KIND_LOAD_A, 3'd0, 3'd1, 16'h8000);
      send_word(mm_pkg::KIND_LOAD_A, 3'd1, 3'd0, 16'h7FFF);
      send_word(mm_pkg::KIND_LOAD_A, 3'd1, 3'd1, 16'h7FFF);
      send_word(mm_pkg::KIND_LOAD_B, 3'd0, 3'd0, 16'h8000);
      send_word(mm_pkg::KIND_LOAD_B, 3'd1, 3'd0, 16'h8000);
      send_word(mm_pkg::KIND_LOAD_B, 3'd0, 3'd1, 16'h7FFF);
      send_word(mm_pkg::KIND_LOAD_B, 3'd1, 3'd1, 16'h0100);
      send_word(mm_pkg::KIND_LOAD_A, 3'd7, 3'd7, 16'hFFFF);
      send_word(mm_pkg::KIND_LOAD_B, 3'd7, 3'd7, 16'h7FFF);
      send_word(KIND_UNUSED, 3'd7, 3'd7, 16'h5A5A);
      send_word(mm_pkg::KIND_START, 3'd7, 3'd7, 16'hFFFF);
      drain();

      // A zero inner length gives all-zero products.
      write_reg(mm_pkg::CSR_INNER_LEN, 4'd0);
      send_word(mm_pkg::KIND_START, 3'd0, 3'd0, 16'h0000);
      drain();

      // Zero rows: the start produces nothing.
      write_reg(mm_pkg::CSR_A_ROWS, 4'd0);
      write_reg(mm_pkg::CSR_INNER_LEN, 4'd1);
      send_word(mm_pkg::KIND_START, 3'd5, 3'd2, 16'h1234);
      drain();

      // A row count above the store size acts as the store size.
      write_reg(mm_pkg::CSR_A_ROWS, 4'd15);
      write_reg(mm_pkg::CSR_B_COLS, 4'd1);
      load_operands(0);
      send_start();
      drain();

      // Zero columns: the start produces nothing.
      write_reg(mm_pkg::CSR_B_COLS, 4'd0);
      send_start();
      drain();

      // Random phases: new dimensions, then load-and-start rounds with noise
      // mixed in; a few rounds end without a start.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         phase++;
         tx_idle_on = ($urandom_range(0, 3) != 0);
         if (phase == 3) begin
            write_reg(mm_pkg::CSR_A_ROWS, 4'd3);
            write_reg(mm_pkg::CSR_INNER_LEN, 4'd3);
            write_reg(mm_pkg::CSR_B_COLS, 4'd3);
            hold_request <= 1'b1;
            rounds = 3;
         end else begin
            if ($urandom_range(0, 1)) write_reg(mm_pkg::CSR_A_ROWS, pick_dim());
            if ($urandom_range(0, 1)) write_reg(mm_pkg::CSR_INNER_LEN, pick_dim());
            write_reg(mm_pkg::CSR_B_COLS, pick_dim());
            rounds = $urandom_range(1, 3);
         end
         repeat (rounds) begin
            repeat ($urandom_range(0, 3)) send_noise();
            load_operands(25);
            if ($urandom_range(0, 9) != 0) send_start();
         end
         drain();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("[matrix_multiply_top] OK");
      end else begin
         $display("[matrix_multiply_top] ERROR");
      end
      $finish;
   end

endmodule
